// ===== hw/rtl/http_request_line_checker_top_assert.svh =====
// Assertion macros for the request line checker.
// Used by modules that clock on clock and reset on reset; no other dependencies.
`ifndef HTTP_REQUEST_LINE_CHECKER_TOP_ASSERT_SVH
`define HTTP_REQUEST_LINE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication
`define HRLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hrlc_pkg.sv =====
// Package for the request line checker: codes, word types and token tables.
// No dependencies.
`timescale 1ns / 1ps

package hrlc_pkg;

   localparam int URI_COUNT_WIDTH_DEFAULT = 13;
   localparam int MAX_URI_WIDTH = 12;
   localparam logic [MAX_URI_WIDTH-1:0] MAX_URI_RESET = 12'd2048;

   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] CONTROL_LIMIT = 8'd32;

   localparam int METHOD_COUNT = 5;
   localparam int VERSION_COUNT = 2;
   localparam logic [3:0] METHOD_LONGEST = 4'd6;
   localparam logic [3:0] VERSION_LEN = 4'd8;
   localparam logic [3:0] POS_TOP = 4'd15;
   localparam logic [1:0] SPACE_TOP = 2'd3;

   localparam logic [1:0] TOKEN_METHOD = 2'd0;
   localparam logic [1:0] TOKEN_URI = 2'd1;
   localparam logic [1:0] TOKEN_VERSION = 2'd2;
   localparam logic [1:0] TOKEN_EXTRA = 2'd3;

   localparam logic [2:0] ERR_OK = 3'd0;
   localparam logic [2:0] ERR_MISSING = 3'd1;
   localparam logic [2:0] ERR_METHOD = 3'd2;
   localparam logic [2:0] ERR_URI = 3'd3;
   localparam logic [2:0] ERR_EXTRA = 3'd4;
   localparam logic [2:0] ERR_VERSION = 3'd5;

   localparam logic [2:0] METHOD_GET = 3'd0;
   localparam logic [2:0] METHOD_POST = 3'd1;
   localparam logic [2:0] METHOD_PATCH = 3'd2;
   localparam logic [2:0] METHOD_PUT = 3'd3;
   localparam logic [2:0] METHOD_DELETE = 3'd4;

   typedef struct packed {
      logic       valid;
      logic       last_byte;
      logic [7:0] line_byte;
   } in_word_type;

   typedef struct packed {
      logic [2:0] error_code;
      logic [2:0] method_code;
      logic       version_minor;
   } rsp_word_type;

   function automatic logic [3:0] method_len(input logic [2:0] idx);
      logic [3:0] len;
      unique case (idx)
         METHOD_GET: len = 4'd3;
         METHOD_POST: len = 4'd4;
         METHOD_PATCH: len = 4'd5;
         METHOD_PUT: len = 4'd3;
         METHOD_DELETE: len = 4'd6;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] method_char(input logic [2:0] idx, input logic [3:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (idx)
         METHOD_GET: begin
            case (pos)
               4'd0: ch = "G";
               4'd1: ch = "E";
               4'd2: ch = "T";
               default: ch = 8'h00;
            endcase
         end
         METHOD_POST: begin
            case (pos)
               4'd0: ch = "P";
               4'd1: ch = "O";
               4'd2: ch = "S";
               4'd3: ch = "T";
               default: ch = 8'h00;
            endcase
         end
         METHOD_PATCH: begin
            case (pos)
               4'd0: ch = "P";
               4'd1: ch = "A";
               4'd2: ch = "T";
               4'd3: ch = "C";
               4'd4: ch = "H";
               default: ch = 8'h00;
            endcase
         end
         METHOD_PUT: begin
            case (pos)
               4'd0: ch = "P";
               4'd1: ch = "U";
               4'd2: ch = "T";
               default: ch = 8'h00;
            endcase
         end
         METHOD_DELETE: begin
            case (pos)
               4'd0: ch = "D";
               4'd1: ch = "E";
               4'd2: ch = "L";
               4'd3: ch = "E";
               4'd4: ch = "T";
               4'd5: ch = "E";
               default: ch = 8'h00;
            endcase
         end
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // sel 0 is HTTP/1.1, sel 1 is HTTP/1.0
   function automatic logic [7:0] version_char(input logic sel, input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0: ch = "H";
         4'd1: ch = "T";
         4'd2: ch = "T";
         4'd3: ch = "P";
         4'd4: ch = "/";
         4'd5: ch = "1";
         4'd6: ch = ".";
         4'd7: ch = sel ? "0" : "1";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/hrlc_input_stage.sv =====
// Input register for the request line checker: holds one byte word.
// Depends on hrlc_pkg.
`timescale 1ns / 1ps

module hrlc_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_line_byte,
   input  logic                req_last_byte,
   input  logic                consume,
   output hrlc_pkg::in_word_type in_word
);

   logic       valid_ff, valid_in;
   logic       last_ff;
   logic [7:0] data_ff;
   logic       load;

   assign req_stall = valid_ff && !consume;
   assign load = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_line_byte;
         last_ff <= req_last_byte;
      end
   end

   assign in_word.valid = valid_ff;
   assign in_word.last_byte = last_ff;
   assign in_word.line_byte = data_ff;

endmodule

// ===== hw/rtl/hrlc_parser.sv =====
// Per-byte line state, length register and result decode for the request line checker.
// Depends on hrlc_pkg and http_request_line_checker_top_assert.svh.
`timescale 1ns / 1ps
`include "http_request_line_checker_top_assert.svh"

module hrlc_parser #(
   parameter int URI_COUNT_WIDTH = hrlc_pkg::URI_COUNT_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_wr_en,
   input  logic [hrlc_pkg::MAX_URI_WIDTH-1:0]      csr_wr_data,
   input  hrlc_pkg::in_word_type                   in_word,
   input  logic                                    out_free,
   output logic                                    consume,
   output logic                                    res_load,
   output hrlc_pkg::rsp_word_type                  res_word,
   output logic [URI_COUNT_WIDTH-1:0]              res_uri_length
);

   localparam int CAP_W = (URI_COUNT_WIDTH > hrlc_pkg::MAX_URI_WIDTH + 1) ?
                          URI_COUNT_WIDTH : hrlc_pkg::MAX_URI_WIDTH + 1;
   localparam logic [CAP_W-1:0] COUNT_TOP = CAP_W'((2 ** URI_COUNT_WIDTH) - 1);

   logic [hrlc_pkg::MAX_URI_WIDTH-1:0] max_uri_ff;
   logic [1:0]                 space_ff, space_in;
   logic [3:0]                 pos_ff, pos_in;
   logic [4:0]                 mcand_ff, mcand_in;
   logic                       moverrun_ff, moverrun_in;
   logic [URI_COUNT_WIDTH-1:0] uri_ff, uri_in;
   logic                       ufault_ff, ufault_in;
   logic                       pdot_ff, pdot_in;
   logic [1:0]                 vcand_ff, vcand_in;
   logic                       voverrun_ff, voverrun_in;

   logic [CAP_W-1:0] count_cap, want, uri_ext, max_ext;
   logic [7:0]       ch;
   logic             method_ok, uri_ok, version_ok;
   logic [2:0]       err, mcode;

   assign consume = in_word.valid && (!in_word.last_byte || out_free);
   assign res_load = consume && in_word.last_byte;
   assign ch = in_word.line_byte;

   assign max_ext = CAP_W'(max_uri_ff);
   assign want = max_ext + CAP_W'(1);
   assign count_cap = (want < COUNT_TOP) ? want : COUNT_TOP;
   assign uri_ext = CAP_W'(uri_ff);

   always_comb begin
      space_in = space_ff;
      pos_in = pos_ff;
      mcand_in = mcand_ff;
      moverrun_in = moverrun_ff;
      uri_in = uri_ff;
      ufault_in = ufault_ff;
      pdot_in = pdot_ff;
      vcand_in = vcand_ff;
      voverrun_in = voverrun_ff;
      if (ch == hrlc_pkg::SPACE_CHAR) begin
         if (space_ff == hrlc_pkg::TOKEN_METHOD) begin
            for (int i = 0; i < hrlc_pkg::METHOD_COUNT; i++) begin
               if (hrlc_pkg::method_len(3'(i)) != pos_ff || moverrun_ff) begin
                  mcand_in[i] = 1'b0;
               end
            end
         end
         if (space_ff != hrlc_pkg::SPACE_TOP) begin
            space_in = space_ff + 2'd1;
         end
         pos_in = '0;
         pdot_in = 1'b0;
      end else begin
         case (space_ff)
            hrlc_pkg::TOKEN_METHOD: begin
               for (int i = 0; i < hrlc_pkg::METHOD_COUNT; i++) begin
                  if (pos_ff >= hrlc_pkg::method_len(3'(i)) ||
                      hrlc_pkg::method_char(3'(i), pos_ff) != ch) begin
                     mcand_in[i] = 1'b0;
                  end
               end
               if (pos_ff >= hrlc_pkg::METHOD_LONGEST) begin
                  moverrun_in = 1'b1;
               end
            end
            hrlc_pkg::TOKEN_URI: begin
               if ((pos_ff == 4'd0 && ch != hrlc_pkg::SLASH_CHAR) ||
                   (ch == hrlc_pkg::DOT_CHAR && pdot_ff) ||
                   (ch < hrlc_pkg::CONTROL_LIMIT)) begin
                  ufault_in = 1'b1;
               end
               pdot_in = (ch == hrlc_pkg::DOT_CHAR);
               if (uri_ext < count_cap) begin
                  uri_in = uri_ff + URI_COUNT_WIDTH'(1);
               end else begin
                  ufault_in = 1'b1;
               end
            end
            hrlc_pkg::TOKEN_VERSION: begin
               for (int i = 0; i < hrlc_pkg::VERSION_COUNT; i++) begin
                  if (pos_ff >= hrlc_pkg::VERSION_LEN ||
                      hrlc_pkg::version_char(1'(i), pos_ff) != ch) begin
                     vcand_in[i] = 1'b0;
                  end
               end
               if (pos_ff >= hrlc_pkg::VERSION_LEN) begin
                  voverrun_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
         if (space_ff != hrlc_pkg::TOKEN_EXTRA && pos_ff != hrlc_pkg::POS_TOP) begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_comb begin
      method_ok = (space_in != hrlc_pkg::TOKEN_METHOD) && (mcand_in != '0);
      uri_ok = (uri_in != '0) && !ufault_in &&
               (CAP_W'(uri_in) <= max_ext);
      version_ok = !voverrun_in && (pos_in == hrlc_pkg::VERSION_LEN) && (vcand_in != '0);
      if (space_in == hrlc_pkg::TOKEN_METHOD) begin
         err = hrlc_pkg::ERR_MISSING;
      end else if (!method_ok) begin
         err = hrlc_pkg::ERR_METHOD;
      end else if (space_in == hrlc_pkg::TOKEN_URI) begin
         err = hrlc_pkg::ERR_MISSING;
      end else if (!uri_ok) begin
         err = hrlc_pkg::ERR_URI;
      end else if (space_in == hrlc_pkg::TOKEN_EXTRA) begin
         err = hrlc_pkg::ERR_EXTRA;
      end else if (!version_ok) begin
         err = hrlc_pkg::ERR_VERSION;
      end else begin
         err = hrlc_pkg::ERR_OK;
      end
      mcode = hrlc_pkg::METHOD_GET;
      if (method_ok) begin
         for (int i = hrlc_pkg::METHOD_COUNT - 1; i >= 0; i--) begin
            if (mcand_in[i]) begin
               mcode = 3'(i);
            end
         end
      end
   end

   assign res_word.error_code = err;
   assign res_word.method_code = mcode;
   assign res_word.version_minor = (err == hrlc_pkg::ERR_OK) ? vcand_in[0] : 1'b0;
   assign res_uri_length = uri_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_uri_ff <= hrlc_pkg::MAX_URI_RESET;
      end else if (csr_wr_en) begin
         max_uri_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || res_load) begin
         space_ff <= '0;
         pos_ff <= '0;
         mcand_ff <= '1;
         moverrun_ff <= 1'b0;
         uri_ff <= '0;
         ufault_ff <= 1'b0;
         pdot_ff <= 1'b0;
         vcand_ff <= '1;
         voverrun_ff <= 1'b0;
      end else if (consume) begin
         space_ff <= space_in;
         pos_ff <= pos_in;
         mcand_ff <= mcand_in;
         moverrun_ff <= moverrun_in;
         uri_ff <= uri_in;
         ufault_ff <= ufault_in;
         pdot_ff <= pdot_in;
         vcand_ff <= vcand_in;
         voverrun_ff <= voverrun_in;
      end
   end

   `HRLC_ASSERT_NEXT(a_line_cleared, res_load,
      space_ff == hrlc_pkg::TOKEN_METHOD && uri_ff == '0 && mcand_ff == '1,
      "line state not cleared after final word")
   `HRLC_ASSERT_NOW(a_uri_capped, 1'b1, uri_ext <= count_cap, "URI count beyond its cap")
   `HRLC_ASSERT_NOW(a_ok_two_spaces, res_load && err == hrlc_pkg::ERR_OK,
      space_in == hrlc_pkg::TOKEN_VERSION && !ufault_in,
      "clean result without exactly two spaces")

endmodule

// ===== hw/rtl/hrlc_result_reg.sv =====
// Result register for the request line checker: holds one result word until taken.
// Depends on hrlc_pkg and http_request_line_checker_top_assert.svh.
`timescale 1ns / 1ps
`include "http_request_line_checker_top_assert.svh"

module hrlc_result_reg #(
   parameter int URI_COUNT_WIDTH = hrlc_pkg::URI_COUNT_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_load,
   input  hrlc_pkg::rsp_word_type     res_word,
   input  logic [URI_COUNT_WIDTH-1:0] res_uri_length,
   output logic                       out_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_error_code,
   output logic [2:0]                 rsp_method_code,
   output logic [URI_COUNT_WIDTH-1:0] rsp_uri_length,
   output logic                       rsp_version_minor
);

   logic                       valid_ff, valid_in;
   hrlc_pkg::rsp_word_type     word_ff;
   logic [URI_COUNT_WIDTH-1:0] uri_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (res_load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         word_ff <= res_word;
         uri_ff <= res_uri_length;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_error_code = word_ff.error_code;
   assign rsp_method_code = word_ff.method_code;
   assign rsp_uri_length = uri_ff;
   assign rsp_version_minor = word_ff.version_minor;

   `HRLC_ASSERT_NOW(a_no_overwrite, valid_ff && rsp_stall, !res_load, "result overwritten while stalled")
   `HRLC_ASSERT_NOW(a_code_range, valid_ff, word_ff.error_code <= hrlc_pkg::ERR_VERSION, "error code out of range")
   `HRLC_ASSERT_NOW(a_minor_only_ok, valid_ff && word_ff.version_minor, word_ff.error_code == hrlc_pkg::ERR_OK, "minor digit set on failed line")

endmodule

// ===== hw/rtl/http_request_line_checker_top.sv =====
// Top level of the HTTP request line checker.
// Depends on hrlc_pkg, hrlc_input_stage, hrlc_parser and hrlc_result_reg.
`timescale 1ns / 1ps
//
// channel  prefix  direction  word
// request  req_    in         line_byte, last_byte
// response rsp_    out        error_code, method_code, uri_length, version_minor
// config   csr_    in         max_uri_length (write only)
//
// One byte word a cycle sustained while no final byte waits on a stalled result; a result word is valid in the cycle
// after its final byte is taken. The input register and the result register sit around the per-byte update.
// A stalled result holds only final byte words back; other bytes keep flowing.
// Synchronous active-high reset; max_uri_length resets to 2048.

module http_request_line_checker_top #(
   parameter int URI_COUNT_WIDTH = hrlc_pkg::URI_COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_line_byte,
   input  logic                                req_last_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_error_code,
   output logic [2:0]                          rsp_method_code,
   output logic [URI_COUNT_WIDTH-1:0]          rsp_uri_length,
   output logic                                rsp_version_minor,
   input  logic                                csr_wr_en,
   input  logic [hrlc_pkg::MAX_URI_WIDTH-1:0]  csr_wr_data
);

   hrlc_pkg::in_word_type      in_word;
   hrlc_pkg::rsp_word_type     res_word;
   logic [URI_COUNT_WIDTH-1:0] res_uri_length;
   logic                       consume, res_load, out_free;

   hrlc_input_stage u_input (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_line_byte(req_line_byte),
      .req_last_byte(req_last_byte),
      .consume      (consume),
      .in_word      (in_word)
   );

   hrlc_parser #(
      .URI_COUNT_WIDTH(URI_COUNT_WIDTH)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .in_word       (in_word),
      .out_free      (out_free),
      .consume       (consume),
      .res_load      (res_load),
      .res_word      (res_word),
      .res_uri_length(res_uri_length)
   );

   hrlc_result_reg #(
      .URI_COUNT_WIDTH(URI_COUNT_WIDTH)
   ) u_result (
      .clock            (clock),
      .reset            (reset),
      .res_load         (res_load),
      .res_word         (res_word),
      .res_uri_length   (res_uri_length),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_error_code   (rsp_error_code),
      .rsp_method_code  (rsp_method_code),
      .rsp_uri_length   (rsp_uri_length),
      .rsp_version_minor(rsp_version_minor)
   );

endmodule
